### rtl/two_phase_rotation_detector_unit_macros.svh
// Assertion macros shared by the rotation detector RTL.
`ifndef TWO_PHASE_ROTATION_DETECTOR_UNIT_MACROS_SVH
`define TWO_PHASE_ROTATION_DETECTOR_UNIT_MACROS_SVH

// Condition holds at every clock edge out of reset.
`define TRPD_ASSERT_HOLDS(label, clk, rst, cond, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// Antecedent implies consequent in the same cycle.
`define TRPD_ASSERT_IMPLIES(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Antecedent implies consequent in the next cycle.
`define TRPD_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

### rtl/trpd_pkg.sv
// Types, constants and helper functions of the rotation detector.
package trpd_pkg;

   localparam int SAMPLE_W    = 8;
   localparam logic [SAMPLE_W-1:0] CENTER = 8'h80;
   localparam int MAX_SAMPLES = 1024;
   localparam int SHIFT_SPAN  = 10;
   localparam int WIN_LEN     = 2 * SHIFT_SPAN + 1;
   localparam int COUNT_W     = $clog2(MAX_SAMPLES + 1);

   // squared difference of two bytes fits 16 bits, energy term 15 bits
   localparam int SQ_W        = 16;
   localparam int ENERGY_SQ_W = 15;

   // adder tree over the shifted terms: groups, then group totals
   localparam int GROUP_LEN   = 4;
   localparam int GROUP_NUM   = (SHIFT_SPAN + GROUP_LEN - 1) / GROUP_LEN;
   localparam int GROUP_SUM_W = SQ_W + $clog2(GROUP_LEN);
   localparam int TERM_SUM_W  = SQ_W + $clog2(SHIFT_SPAN + 1);

   // accumulator widths
   localparam int ENERGY_W    = 25;
   localparam int ALIGNED_W   = 27;
   localparam int SHIFT_SUM_W = 31;
   localparam int TRIPLE_W    = ALIGNED_W + 2;

   // truncating divide by SHIFT_SPAN as multiply by rounded-up reciprocal
   localparam int DIV_SHIFT   = SHIFT_SUM_W + $clog2(SHIFT_SPAN);
   localparam int MAGIC_W     = DIV_SHIFT - $clog2(SHIFT_SPAN) + 1;
   localparam longint unsigned DIV_MAGIC_FULL =
      ((64'd1 << DIV_SHIFT) + SHIFT_SPAN - 1) / SHIFT_SPAN;
   localparam logic [MAGIC_W-1:0] DIV_MAGIC = MAGIC_W'(DIV_MAGIC_FULL);
   localparam int PROD_W      = SHIFT_SUM_W + MAGIC_W;
   localparam int QUOT_W      = PROD_W - DIV_SHIFT;

   typedef enum logic [1:0] {
      DIR_NONE    = 2'd0,
      DIR_FORWARD = 2'd1,
      DIR_REVERSE = 2'd2
   } dir_type;

   // control carried alongside each beat in the front pipeline
   typedef struct packed {
      logic valid;
      logic contrib;
      logic last;
   } beat_ctl_type;

   // final sums of one capture
   typedef struct packed {
      logic [ENERGY_W-1:0]    main_energy;
      logic [ENERGY_W-1:0]    aux_energy;
      logic [ALIGNED_W-1:0]   aligned;
      logic [SHIFT_SUM_W-1:0] later;
      logic [SHIFT_SUM_W-1:0] earlier;
   } totals_type;

   // square of the difference of two offset-binary bytes
   function automatic logic [SQ_W-1:0] sq_diff(input logic [SAMPLE_W-1:0] x,
                                               input logic [SAMPLE_W-1:0] y);
      logic signed [SAMPLE_W:0]     d;
      logic signed [2*SAMPLE_W+1:0] p;
      d = $signed({1'b0, x}) - $signed({1'b0, y});
      p = d * d;
      return p[SQ_W-1:0];
   endfunction

endpackage

### rtl/trpd_req_if.sv
// Sample pair channel.
interface trpd_req_if;
   logic                          valid;
   logic                          ready;
   logic [trpd_pkg::SAMPLE_W-1:0] main_sample;
   logic [trpd_pkg::SAMPLE_W-1:0] aux_sample;
   logic                          last_sample;

   modport source (output valid, output main_sample, output aux_sample,
                   output last_sample, input ready);
   modport sink   (input valid, input main_sample, input aux_sample,
                   input last_sample, output ready);
endinterface

### rtl/trpd_rsp_if.sv
// Classification result channel.
interface trpd_rsp_if;
   logic       valid;
   logic       ready;
   logic [1:0] direction;
   logic       pass;

   modport source (output valid, output direction, output pass, input ready);
   modport sink   (input valid, input direction, input pass, output ready);
endinterface

### rtl/trpd_cell.sv
// One tap of the auxiliary window: holds a sample, shifts it on, squares its
// difference against the main center sample.
module trpd_cell (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          shift_en,
   input  logic                          sq_en,
   input  logic [trpd_pkg::SAMPLE_W-1:0] tap_in,
   input  logic [trpd_pkg::SAMPLE_W-1:0] main_center,
   output logic [trpd_pkg::SAMPLE_W-1:0] tap_out,
   output logic [trpd_pkg::SQ_W-1:0]     sq_out
);

   logic [trpd_pkg::SAMPLE_W-1:0] tap_ff;
   logic [trpd_pkg::SQ_W-1:0]     sq_ff;
   logic [trpd_pkg::SQ_W-1:0]     sq_in;

   assign sq_in = trpd_pkg::sq_diff(main_center, tap_ff);

   // tap register, reset to mid-scale
   always_ff @(posedge clock) begin
      if (reset) begin
         tap_ff <= trpd_pkg::CENTER;
      end else if (shift_en) begin
         tap_ff <= tap_in;
      end
   end

   // registered square
   always_ff @(posedge clock) begin
      if (sq_en) begin
         sq_ff <= sq_in;
      end
   end

   assign tap_out = tap_ff;
   assign sq_out  = sq_ff;

endmodule

### rtl/trpd_accum.sv
// Adder tree over the shifted squares and the capture accumulators.
module trpd_accum (
   input  logic                             clock,
   input  logic                             reset,
   input  trpd_pkg::beat_ctl_type           s1_ctl,
   input  logic [trpd_pkg::SQ_W-1:0]        later_sq   [trpd_pkg::SHIFT_SPAN],
   input  logic [trpd_pkg::SQ_W-1:0]        earlier_sq [trpd_pkg::SHIFT_SPAN],
   input  logic [trpd_pkg::SQ_W-1:0]        aligned_sq,
   input  logic [trpd_pkg::ENERGY_SQ_W-1:0] main_sq,
   input  logic [trpd_pkg::ENERGY_SQ_W-1:0] aux_sq,
   input  logic                             snap_ready,
   output logic                             go,
   output logic                             snap_valid,
   output trpd_pkg::totals_type             snap
);

   localparam int PAD_LEN = trpd_pkg::GROUP_NUM * trpd_pkg::GROUP_LEN;

   logic [trpd_pkg::SQ_W-1:0]        later_pad   [PAD_LEN];
   logic [trpd_pkg::SQ_W-1:0]        earlier_pad [PAD_LEN];
   logic [trpd_pkg::GROUP_SUM_W-1:0] later_grp_in    [trpd_pkg::GROUP_NUM];
   logic [trpd_pkg::GROUP_SUM_W-1:0] earlier_grp_in  [trpd_pkg::GROUP_NUM];
   logic [trpd_pkg::GROUP_SUM_W-1:0] later_grp_ff    [trpd_pkg::GROUP_NUM];
   logic [trpd_pkg::GROUP_SUM_W-1:0] earlier_grp_ff  [trpd_pkg::GROUP_NUM];
   logic [trpd_pkg::TERM_SUM_W-1:0]  later_term_in, earlier_term_in;
   logic [trpd_pkg::TERM_SUM_W-1:0]  later_term_ff, earlier_term_ff;
   logic [trpd_pkg::SQ_W-1:0]        aligned_s2_ff, aligned_s3_ff;
   logic [trpd_pkg::ENERGY_SQ_W-1:0] main_s2_ff, main_s3_ff;
   logic [trpd_pkg::ENERGY_SQ_W-1:0] aux_s2_ff, aux_s3_ff;
   trpd_pkg::beat_ctl_type           s2_ctl_ff, s3_ctl_ff;
   trpd_pkg::totals_type             acc_ff, acc_in, acc_sum;

   // pad the term lists to whole groups
   for (genvar i = 0; i < PAD_LEN; i++) begin : g_pad
      if (i < trpd_pkg::SHIFT_SPAN) begin : g_real
         assign later_pad[i]   = later_sq[i];
         assign earlier_pad[i] = earlier_sq[i];
      end else begin : g_zero
         assign later_pad[i]   = '0;
         assign earlier_pad[i] = '0;
      end
   end

   // first tree level: group sums
   always_comb begin
      for (int g = 0; g < trpd_pkg::GROUP_NUM; g++) begin
         later_grp_in[g]   = '0;
         earlier_grp_in[g] = '0;
         for (int k = 0; k < trpd_pkg::GROUP_LEN; k++) begin
            later_grp_in[g] = later_grp_in[g] +
               trpd_pkg::GROUP_SUM_W'(later_pad[g * trpd_pkg::GROUP_LEN + k]);
            earlier_grp_in[g] = earlier_grp_in[g] +
               trpd_pkg::GROUP_SUM_W'(earlier_pad[g * trpd_pkg::GROUP_LEN + k]);
         end
      end
   end

   // second tree level: totals of the groups
   always_comb begin
      later_term_in   = '0;
      earlier_term_in = '0;
      for (int g = 0; g < trpd_pkg::GROUP_NUM; g++) begin
         later_term_in   = later_term_in + trpd_pkg::TERM_SUM_W'(later_grp_ff[g]);
         earlier_term_in = earlier_term_in + trpd_pkg::TERM_SUM_W'(earlier_grp_ff[g]);
      end
   end

   // stall only when a final beat finds the classifier full
   assign snap_valid = s3_ctl_ff.valid && s3_ctl_ff.last;
   assign go         = !(snap_valid && !snap_ready);

   // accumulator sums including the beat in stage 3
   always_comb begin
      acc_sum.main_energy = acc_ff.main_energy + trpd_pkg::ENERGY_W'(main_s3_ff);
      acc_sum.aux_energy  = acc_ff.aux_energy + trpd_pkg::ENERGY_W'(aux_s3_ff);
      acc_sum.aligned     = acc_ff.aligned + trpd_pkg::ALIGNED_W'(aligned_s3_ff);
      acc_sum.later       = acc_ff.later + trpd_pkg::SHIFT_SUM_W'(later_term_ff);
      acc_sum.earlier     = acc_ff.earlier + trpd_pkg::SHIFT_SUM_W'(earlier_term_ff);
      snap = s3_ctl_ff.contrib ? acc_sum : acc_ff;
      acc_in = acc_ff;
      if (s3_ctl_ff.valid) begin
         if (s3_ctl_ff.last) begin
            acc_in = '0;
         end else if (s3_ctl_ff.contrib) begin
            acc_in = acc_sum;
         end
      end
   end

   // tree and accumulator control
   always_ff @(posedge clock) begin
      if (reset) begin
         s2_ctl_ff <= '0;
         s3_ctl_ff <= '0;
         acc_ff    <= '0;
      end else if (go) begin
         s2_ctl_ff <= s1_ctl;
         s3_ctl_ff <= s2_ctl_ff;
         acc_ff    <= acc_in;
      end
   end

   // tree payload
   always_ff @(posedge clock) begin
      if (go) begin
         later_grp_ff    <= later_grp_in;
         earlier_grp_ff  <= earlier_grp_in;
         later_term_ff   <= later_term_in;
         earlier_term_ff <= earlier_term_in;
         aligned_s2_ff   <= aligned_sq;
         aligned_s3_ff   <= aligned_s2_ff;
         main_s2_ff      <= main_sq;
         main_s3_ff      <= main_s2_ff;
         aux_s2_ff       <= aux_sq;
         aux_s3_ff       <= aux_s2_ff;
      end
   end

endmodule

### rtl/trpd_classify.sv
// Result pipeline: divide the shift sums, classify, register the result beat.
module trpd_classify (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 snap_valid,
   input  trpd_pkg::totals_type snap,
   output logic                 snap_ready,
   input  logic [1:0]           expected_direction,
   trpd_rsp_if.source           rsp
);

   logic                          r0_valid_ff, r1_valid_ff, out_valid_ff;
   trpd_pkg::totals_type          r0_ff;
   logic [trpd_pkg::QUOT_W-1:0]   quot_later_ff, quot_earlier_ff;
   logic                          quiet_ff, quiet_in;
   logic [trpd_pkg::PROD_W-1:0]   prod_later, prod_earlier;
   logic [trpd_pkg::TRIPLE_W-1:0] triple_aligned, main_ext, aux_ext;
   trpd_pkg::dir_type             dir_ff, dir_in;
   logic                          pass_ff, pass_in;
   logic                          out_load, r1_load;

   // elastic handshake between the three stages
   assign out_load   = r1_valid_ff && (!out_valid_ff || rsp.ready);
   assign r1_load    = r0_valid_ff && (!r1_valid_ff || out_load);
   assign snap_ready = !r0_valid_ff || r1_load;

   // reciprocal multiply and energy checks
   always_comb begin
      prod_later   = trpd_pkg::PROD_W'(r0_ff.later) * trpd_pkg::PROD_W'(trpd_pkg::DIV_MAGIC);
      prod_earlier = trpd_pkg::PROD_W'(r0_ff.earlier) *
                     trpd_pkg::PROD_W'(trpd_pkg::DIV_MAGIC);
      triple_aligned = {r0_ff.aligned, 1'b0} + trpd_pkg::TRIPLE_W'(r0_ff.aligned);
      main_ext = trpd_pkg::TRIPLE_W'(r0_ff.main_energy);
      aux_ext  = trpd_pkg::TRIPLE_W'(r0_ff.aux_energy);
      quiet_in = (triple_aligned < main_ext && triple_aligned < aux_ext) ||
                 (r0_ff.main_energy < (r0_ff.aux_energy >> 4)) ||
                 (r0_ff.aux_energy < (r0_ff.main_energy >> 4));
   end

   // direction decision and pass flag
   always_comb begin
      if (quiet_ff) begin
         dir_in = trpd_pkg::DIR_NONE;
      end else if (quot_later_ff < quot_earlier_ff) begin
         dir_in = trpd_pkg::DIR_FORWARD;
      end else if (quot_later_ff > quot_earlier_ff) begin
         dir_in = trpd_pkg::DIR_REVERSE;
      end else begin
         dir_in = trpd_pkg::DIR_NONE;
      end
      pass_in = (dir_in != trpd_pkg::DIR_NONE) && (dir_in == expected_direction);
   end

   // stage valids
   always_ff @(posedge clock) begin
      if (reset) begin
         r0_valid_ff  <= 1'b0;
         r1_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         if (snap_ready) begin
            r0_valid_ff <= snap_valid;
         end
         if (!r1_valid_ff || out_load) begin
            r1_valid_ff <= r0_valid_ff;
         end
         if (!out_valid_ff || rsp.ready) begin
            out_valid_ff <= r1_valid_ff;
         end
      end
   end

   // stage payloads
   always_ff @(posedge clock) begin
      if (snap_ready) begin
         r0_ff <= snap;
      end
      if (r1_load) begin
         quot_later_ff   <= prod_later[trpd_pkg::PROD_W-1:trpd_pkg::DIV_SHIFT];
         quot_earlier_ff <= prod_earlier[trpd_pkg::PROD_W-1:trpd_pkg::DIV_SHIFT];
         quiet_ff        <= quiet_in;
      end
      if (out_load) begin
         dir_ff  <= dir_in;
         pass_ff <= pass_in;
      end
   end

   assign rsp.valid     = out_valid_ff;
   assign rsp.direction = dir_ff;
   assign rsp.pass      = pass_ff;

endmodule

### rtl/two_phase_rotation_detector_unit.sv
// Top level of the two-phase rotation detector.
// Throughput: one sample beat per cycle; input stalls only when three results wait.
// The result of a last beat passes stages 0 to 3, then the classifier stages r0, r1 and out.
// Every beat passes the tap cells, a two-level adder tree and the accumulators.
// Reset (synchronous, active high) sets all taps to mid-scale, clears sums and
// count, and sets the expected direction to forward.
`include "two_phase_rotation_detector_unit_macros.svh"

module two_phase_rotation_detector_unit (
   input  logic       clock,
   input  logic       reset,
   trpd_req_if.sink   req,
   trpd_rsp_if.source rsp,
   input  logic       csr_write_enable,
   input  logic [1:0] csr_write_data
);

   localparam int SPAN = trpd_pkg::SHIFT_SPAN;

   logic [1:0]                       expected_ff;
   logic [trpd_pkg::COUNT_W-1:0]     count_ff, count_in;
   logic [trpd_pkg::SAMPLE_W-1:0]    main_dly_ff [SPAN];
   logic [trpd_pkg::SAMPLE_W-1:0]    main_center_ff;
   trpd_pkg::beat_ctl_type           s0_ctl_ff, s0_ctl_in, s1_ctl_ff;
   logic [trpd_pkg::SAMPLE_W-1:0]    tap [trpd_pkg::WIN_LEN];
   logic [trpd_pkg::SQ_W-1:0]        cell_sq [trpd_pkg::WIN_LEN];
   logic [trpd_pkg::SQ_W-1:0]        later_sq   [SPAN];
   logic [trpd_pkg::SQ_W-1:0]        earlier_sq [SPAN];
   logic [trpd_pkg::SQ_W-1:0]        main_sq_full, aux_sq_full;
   logic [trpd_pkg::ENERGY_SQ_W-1:0] main_sq_ff, aux_sq_ff;
   logic                             go, accept, take, shift_en;
   logic                             snap_valid, snap_ready;
   trpd_pkg::totals_type             snap;

   assign req.ready = go;
   assign accept    = req.valid && go;
   assign take      = count_ff < trpd_pkg::COUNT_W'(trpd_pkg::MAX_SAMPLES);
   assign shift_en  = accept && take;

   // expected direction register
   always_ff @(posedge clock) begin
      if (reset) begin
         expected_ff <= trpd_pkg::DIR_FORWARD;
      end else if (csr_write_enable) begin
         expected_ff <= csr_write_data;
      end
   end

   // beat control and sample count
   always_comb begin
      s0_ctl_in.valid   = accept;
      s0_ctl_in.contrib = shift_en &&
                          (count_ff >= trpd_pkg::COUNT_W'(2 * trpd_pkg::SHIFT_SPAN));
      s0_ctl_in.last    = accept && req.last_sample;
      count_in = count_ff;
      if (accept) begin
         if (req.last_sample) begin
            count_in = '0;
         end else if (take) begin
            count_in = count_ff + 1'b1;
         end
      end
   end

   // main delay line and control of stage 0
   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff       <= '0;
         s0_ctl_ff      <= '0;
         s1_ctl_ff      <= '0;
         main_center_ff <= trpd_pkg::CENTER;
         for (int k = 0; k < SPAN; k++) begin
            main_dly_ff[k] <= trpd_pkg::CENTER;
         end
      end else if (go) begin
         count_ff  <= count_in;
         s0_ctl_ff <= s0_ctl_in;
         s1_ctl_ff <= s0_ctl_ff;
         if (shift_en) begin
            main_center_ff <= main_dly_ff[0];
            for (int k = 0; k < SPAN - 1; k++) begin
               main_dly_ff[k] <= main_dly_ff[k + 1];
            end
            main_dly_ff[SPAN-1] <= req.main_sample;
         end
      end
   end

   // row of auxiliary tap cells, newest sample enters at the top
   for (genvar i = 0; i < trpd_pkg::WIN_LEN; i++) begin : g_cell
      logic [trpd_pkg::SAMPLE_W-1:0] tap_in;
      if (i == trpd_pkg::WIN_LEN - 1) begin : g_head
         assign tap_in = req.aux_sample;
      end else begin : g_body
         assign tap_in = tap[i + 1];
      end
      trpd_cell u_cell (
         .clock       (clock),
         .reset       (reset),
         .shift_en    (shift_en),
         .sq_en       (go),
         .tap_in      (tap_in),
         .main_center (main_center_ff),
         .tap_out     (tap[i]),
         .sq_out      (cell_sq[i])
      );
   end

   // later taps sit above the center cell, earlier taps below
   for (genvar j = 0; j < SPAN; j++) begin : g_split
      assign later_sq[j]   = cell_sq[SPAN + 1 + j];
      assign earlier_sq[j] = cell_sq[SPAN - 1 - j];
   end

   // energy squares of the center samples
   assign main_sq_full = trpd_pkg::sq_diff(main_center_ff, trpd_pkg::CENTER);
   assign aux_sq_full  = trpd_pkg::sq_diff(tap[SPAN], trpd_pkg::CENTER);

   always_ff @(posedge clock) begin
      if (go) begin
         main_sq_ff <= main_sq_full[trpd_pkg::ENERGY_SQ_W-1:0];
         aux_sq_ff  <= aux_sq_full[trpd_pkg::ENERGY_SQ_W-1:0];
      end
   end

   trpd_accum u_accum (
      .clock      (clock),
      .reset      (reset),
      .s1_ctl     (s1_ctl_ff),
      .later_sq   (later_sq),
      .earlier_sq (earlier_sq),
      .aligned_sq (cell_sq[SPAN]),
      .main_sq    (main_sq_ff),
      .aux_sq     (aux_sq_ff),
      .snap_ready (snap_ready),
      .go         (go),
      .snap_valid (snap_valid),
      .snap       (snap)
   );

   trpd_classify u_classify (
      .clock              (clock),
      .reset              (reset),
      .snap_valid         (snap_valid),
      .snap               (snap),
      .snap_ready         (snap_ready),
      .expected_direction (expected_ff),
      .rsp                (rsp)
   );

   // checks
   `TRPD_ASSERT_HOLDS(a_count_range, clock, reset, count_ff <= trpd_pkg::COUNT_W'(trpd_pkg::MAX_SAMPLES), "sample count beyond capacity")
   `TRPD_ASSERT_NEXT(a_last_clears, clock, reset, accept && req.last_sample, count_ff == '0, "count not cleared after last beat")
   `TRPD_ASSERT_IMPLIES(a_pass_dir, clock, reset, rsp.valid && rsp.pass, rsp.direction == expected_ff && rsp.direction != trpd_pkg::DIR_NONE, "pass without matching direction")

endmodule

### tb/sv/tb.sv
// Self-checking testbench of the two-phase rotation detector: waveform captures vs a predictor.
module tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int HALF_PERIOD    = 4;
   localparam int RESET_CYCLES   = 12;
   localparam int RESULT_LATENCY = 6;
   localparam int DRAIN_CYCLES   = RESULT_LATENCY + 10;
   localparam int LONG_HOLD      = 600;
   localparam int HOLD_AFTER     = 10;
   localparam int NUM_PHASES     = 6;
   localparam int PHASE_BEATS    = 110;
   localparam int CYCLE_LIMIT    = 300000;
   localparam logic [1:0] DIR_INVALID = 2'd3;

   typedef logic [trpd_pkg::SAMPLE_W-1:0] sample_type;

   typedef struct packed {
      sample_type main_s;
      sample_type aux_s;
      logic       last;
   } sample_beat_type;

   typedef struct packed {
      trpd_pkg::dir_type direction;
      logic              pass;
   } verdict_type;

   typedef enum int {
      WAVE_LEADING,
      WAVE_LAGGING,
      WAVE_IN_STEP,
      WAVE_ONE_SIDED,
      WAVE_NOISE,
      WAVE_FLAT
   } wave_kind_type;

   typedef enum int {
      RX_OPEN,
      RX_CHOPPY,
      RX_SLUGGISH
   } rx_mode_type;

   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       csr_write_enable;
   logic [1:0] csr_write_data;

   trpd_req_if req_if ();
   trpd_rsp_if rsp_if ();

   two_phase_rotation_detector_unit u_dut (
      .clock            (clock),
      .reset            (reset),
      .req              (req_if),
      .rsp              (rsp_if),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data)
   );

   always #(HALF_PERIOD) clock = ~clock;

   // stimulus and scoreboard storage
   sample_beat_type beats_pending[$];
   verdict_type     verdicts_due[$];
   int              beats_queued   = 0;
   int              beats_accepted = 0;
   int              captures_sent  = 0;
   int              results_seen   = 0;
   int              forward_seen   = 0;
   int              reverse_seen   = 0;
   int              none_seen      = 0;
   int              pass_seen      = 0;
   int              error_count    = 0;
   int              cycle_count    = 0;

   // predictor state
   sample_type                       aux_taps[trpd_pkg::WIN_LEN];
   sample_type                       main_taps[trpd_pkg::SHIFT_SPAN];
   logic [trpd_pkg::COUNT_W-1:0]     cap_count;
   logic [trpd_pkg::ENERGY_W-1:0]    main_sum;
   logic [trpd_pkg::ENERGY_W-1:0]    aux_sum;
   logic [trpd_pkg::ALIGNED_W-1:0]   aligned_sum;
   logic [trpd_pkg::SHIFT_SUM_W-1:0] later_sum;
   logic [trpd_pkg::SHIFT_SUM_W-1:0] earlier_sum;
   logic [1:0]                       dir_setting;

   task automatic report_mismatch(input string what, input int got, input int want);
      $display("MISMATCH at result %0d: %s got %0d want %0d", results_seen, what, got, want);
      error_count = error_count + 1;
   endtask

   function automatic int unsigned squared_gap(input int x, input int y);
      int d;
      d = x - y;
      return d * d;
   endfunction

   task automatic clear_capture_sums();
      cap_count   = '0;
      main_sum    = '0;
      aux_sum     = '0;
      aligned_sum = '0;
      later_sum   = '0;
      earlier_sum = '0;
   endtask

   // advance the predictor by one accepted beat; a last beat yields a verdict
   task automatic predict_beat(input sample_beat_type b);
      sample_type      main_mid;
      int              p1;
      int              p2;
      longint unsigned later_avg;
      longint unsigned earlier_avg;
      longint unsigned triple;
      longint unsigned me;
      longint unsigned ae;
      verdict_type     v;
      if (cap_count < trpd_pkg::MAX_SAMPLES) begin
         main_mid = main_taps[0];
         for (int k = 0; k < trpd_pkg::WIN_LEN - 1; k++) aux_taps[k] = aux_taps[k + 1];
         aux_taps[trpd_pkg::WIN_LEN - 1] = b.aux_s;
         if (cap_count >= 2 * trpd_pkg::SHIFT_SPAN) begin
            p1 = int'(main_mid) - int'(trpd_pkg::CENTER);
            p2 = int'(aux_taps[trpd_pkg::SHIFT_SPAN]) - int'(trpd_pkg::CENTER);
            main_sum    = main_sum + squared_gap(p1, 0);
            aux_sum     = aux_sum + squared_gap(p2, 0);
            aligned_sum = aligned_sum + squared_gap(p1, p2);
            for (int j = 1; j <= trpd_pkg::SHIFT_SPAN; j++) begin
               later_sum = later_sum +
                  squared_gap(p1, int'(aux_taps[trpd_pkg::SHIFT_SPAN + j]) -
                                  int'(trpd_pkg::CENTER));
               earlier_sum = earlier_sum +
                  squared_gap(p1, int'(aux_taps[trpd_pkg::SHIFT_SPAN - j]) -
                                  int'(trpd_pkg::CENTER));
            end
         end
         for (int k = 0; k < trpd_pkg::SHIFT_SPAN - 1; k++) main_taps[k] = main_taps[k + 1];
         main_taps[trpd_pkg::SHIFT_SPAN - 1] = b.main_s;
         cap_count = cap_count + 1'b1;
      end
      if (b.last) begin
         later_avg   = longint'(later_sum) / trpd_pkg::SHIFT_SPAN;
         earlier_avg = longint'(earlier_sum) / trpd_pkg::SHIFT_SPAN;
         triple      = 3 * longint'(aligned_sum);
         me          = longint'(main_sum);
         ae          = longint'(aux_sum);
         if ((triple < me && triple < ae) || me < (ae >> 4) || ae < (me >> 4))
            v.direction = trpd_pkg::DIR_NONE;
         else if (later_avg < earlier_avg)
            v.direction = trpd_pkg::DIR_FORWARD;
         else if (later_avg > earlier_avg)
            v.direction = trpd_pkg::DIR_REVERSE;
         else
            v.direction = trpd_pkg::DIR_NONE;
         v.pass = (v.direction != trpd_pkg::DIR_NONE) && (v.direction == dir_setting);
         verdicts_due.push_back(v);
         clear_capture_sums();
      end
   endtask

   // triangle wave, amplitude amp, period per, any integer phase t
   function automatic int tri_point(input int t, input int per, input int amp);
      int p;
      p = ((t % per) + per) % per;
      if (2 * p < per) return -amp + (4 * amp * p) / per;
      return 3 * amp - (4 * amp * p) / per;
   endfunction

   function automatic sample_type clamp_byte(input int v);
      int s;
      s = v + int'(trpd_pkg::CENTER);
      if (s < 0) s = 0;
      if (s > 255) s = 255;
      return sample_type'(s);
   endfunction

   task automatic queue_beat(input sample_type m, input sample_type a, input logic last);
      sample_beat_type b;
      b.main_s = m;
      b.aux_s  = a;
      b.last   = last;
      beats_pending.push_back(b);
      beats_queued = beats_queued + 1;
      if (last) captures_sent = captures_sent + 1;
   endtask

   // one capture of paired waveforms of the given kind, last flag on its final beat
   task automatic queue_capture(input wave_kind_type kind, input int len);
      int   per;
      int   amp;
      int   noise;
      int   start;
      int   lag;
      int   m;
      int   a;
      logic flip;
      per   = $urandom_range(8, 40);
      amp   = $urandom_range(24, 150);
      noise = $urandom_range(0, 10);
      start = $urandom_range(0, per - 1);
      lag   = per / 4 + int'($urandom_range(0, 2)) - 1;
      flip  = 1'($urandom_range(0, 1));
      for (int t = 0; t < len; t++) begin
         m = tri_point(start + t, per, amp) + int'($urandom_range(0, 2 * noise)) - noise;
         case (kind)
            WAVE_LEADING: begin
               a = tri_point(start + t - lag, per, amp) + int'($urandom_range(0, 2 * noise))
                   - noise;
            end
            WAVE_LAGGING: begin
               a = tri_point(start + t + lag, per, amp) + int'($urandom_range(0, 2 * noise))
                   - noise;
            end
            WAVE_IN_STEP: begin
               a = m + int'($urandom_range(0, 4)) - 2;
            end
            WAVE_ONE_SIDED: begin
               a = int'($urandom_range(0, 6)) - 3;
               if (flip) begin
                  a = m;
                  m = int'($urandom_range(0, 6)) - 3;
               end
            end
            WAVE_NOISE: begin
               m = int'($urandom_range(0, 255)) - int'(trpd_pkg::CENTER);
               a = int'($urandom_range(0, 255)) - int'(trpd_pkg::CENTER);
            end
            default: begin
               m = int'($urandom_range(0, 2)) - 1;
               a = int'($urandom_range(0, 2)) - 1;
            end
         endcase
         queue_beat(clamp_byte(m), clamp_byte(a), t == len - 1);
      end
   endtask

   // block is idle once every queued beat is in and every verdict is out
   task automatic wait_for_drain();
      while (beats_accepted != beats_queued || verdicts_due.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic set_expected_direction(input logic [1:0] v);
      @(posedge clock);
      csr_write_enable <= 1'b1;
      csr_write_data   <= v;
      @(posedge clock);
      csr_write_enable <= 1'b0;
      dir_setting = v;
   endtask

   // sample beat driver: bursts with random gaps
   sample_beat_type beat_on_bus;
   int              burst_left;
   int              gap_left;

   always @(posedge clock) begin
      if (reset) begin
         req_if.valid <= 1'b0;
         burst_left = $urandom_range(1, 40);
         gap_left   = 0;
      end else begin
         if (req_if.valid && req_if.ready) begin
            predict_beat(beat_on_bus);
            beats_accepted = beats_accepted + 1;
         end
         if (!req_if.valid || req_if.ready) begin
            if (gap_left > 0) begin
               gap_left = gap_left - 1;
               req_if.valid <= 1'b0;
            end else if (beats_pending.size() > 0) begin
               beat_on_bus = beats_pending.pop_front();
               req_if.valid       <= 1'b1;
               req_if.main_sample <= beat_on_bus.main_s;
               req_if.aux_sample  <= beat_on_bus.aux_s;
               req_if.last_sample <= beat_on_bus.last;
               burst_left = burst_left - 1;
               if (burst_left == 0) begin
                  burst_left = $urandom_range(1, 40);
                  gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
               end
            end else begin
               req_if.valid <= 1'b0;
            end
         end
      end
   end

   // result receiver: stall pattern of its own plus one long hold-off
   int          hold_left;
   logic        hold_done;
   int          mode_left;
   rx_mode_type ready_mode;

   always @(posedge clock) begin
      if (reset) begin
         rsp_if.ready <= 1'b0;
         hold_left  = 0;
         hold_done  = 1'b0;
         mode_left  = 0;
         ready_mode = RX_OPEN;
      end else if (hold_left > 0) begin
         hold_left = hold_left - 1;
         rsp_if.ready <= 1'b0;
      end else if (!hold_done && results_seen >= HOLD_AFTER) begin
         hold_done = 1'b1;
         hold_left = LONG_HOLD;
         rsp_if.ready <= 1'b0;
      end else begin
         if (mode_left == 0) begin
            ready_mode = rx_mode_type'($urandom_range(0, 2));
            mode_left  = $urandom_range(10, 80);
         end
         mode_left = mode_left - 1;
         case (ready_mode)
            RX_OPEN:   rsp_if.ready <= 1'b1;
            RX_CHOPPY: rsp_if.ready <= 1'($urandom_range(0, 1));
            default:   rsp_if.ready <= ($urandom_range(0, 3) == 0);
         endcase
      end
   end

   // result monitor: compare each result beat with the oldest verdict
   verdict_type got_verdict;

   always @(posedge clock) begin
      if (!reset && rsp_if.valid && rsp_if.ready) begin
         if (verdicts_due.size() == 0) begin
            report_mismatch("unexpected result, direction", rsp_if.direction, -1);
         end else begin
            got_verdict = verdicts_due.pop_front();
            if (rsp_if.direction !== got_verdict.direction)
               report_mismatch("direction", rsp_if.direction, got_verdict.direction);
            if (rsp_if.pass !== got_verdict.pass)
               report_mismatch("pass", rsp_if.pass, got_verdict.pass);
            case (got_verdict.direction)
               trpd_pkg::DIR_FORWARD: forward_seen = forward_seen + 1;
               trpd_pkg::DIR_REVERSE: reverse_seen = reverse_seen + 1;
               default:               none_seen    = none_seen + 1;
            endcase
            if (got_verdict.pass) pass_seen = pass_seen + 1;
         end
         results_seen <= results_seen + 1;
      end
   end

   // watchdog
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d verdicts pending", cycle_count,
                  verdicts_due.size());
         $display("== FAIL ==");
         $finish;
      end
   end

   // test sequence
   initial begin
      logic [1:0]    phase_dirs[NUM_PHASES];
      int            phase_beats;
      int            len;
      int            pick;
      wave_kind_type kind;

      req_if.valid       = 1'b0;
      req_if.main_sample = trpd_pkg::CENTER;
      req_if.aux_sample  = trpd_pkg::CENTER;
      req_if.last_sample = 1'b0;
      rsp_if.ready       = 1'b0;
      csr_write_enable   = 1'b0;
      csr_write_data     = '0;

      for (int k = 0; k < trpd_pkg::WIN_LEN; k++) aux_taps[k] = trpd_pkg::CENTER;
      for (int k = 0; k < trpd_pkg::SHIFT_SPAN; k++) main_taps[k] = trpd_pkg::CENTER;
      clear_capture_sums();
      dir_setting = trpd_pkg::DIR_FORWARD;

      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;

      // directed: extremes in a short capture, a one-beat capture, one-centre capture
      queue_beat(8'h00, 8'hFF, 1'b0);
      queue_beat(8'hFF, 8'h00, 1'b0);
      queue_beat(8'hFF, 8'hFF, 1'b1);
      queue_beat(8'h00, 8'h00, 1'b1);
      for (int t = 0; t < 2 * trpd_pkg::SHIFT_SPAN + 1; t++)
         queue_beat(((t / 2) % 2) ? 8'hFF : 8'h00, (((t + 1) / 2) % 2) ? 8'hFF : 8'h00,
                    t == 2 * trpd_pkg::SHIFT_SPAN);
      wait_for_drain();

      phase_dirs[0] = trpd_pkg::DIR_REVERSE;
      phase_dirs[1] = trpd_pkg::DIR_NONE;
      phase_dirs[2] = DIR_INVALID;
      phase_dirs[3] = trpd_pkg::DIR_FORWARD;
      phase_dirs[4] = 2'($urandom_range(0, 3));
      phase_dirs[5] = 2'($urandom_range(1, 2));

      for (int phase = 0; phase < NUM_PHASES; phase++) begin
         set_expected_direction(phase_dirs[phase]);
         phase_beats = 0;
         // beyond-capacity capture: extra beats past the limit are dropped
         if (phase == 3) begin
            queue_capture(WAVE_LEADING, trpd_pkg::MAX_SAMPLES + 5);
            phase_beats = trpd_pkg::MAX_SAMPLES;
         end
         while (phase_beats < PHASE_BEATS) begin
            pick = $urandom_range(0, 9);
            if (pick < 3) kind = WAVE_LEADING;
            else if (pick < 6) kind = WAVE_LAGGING;
            else if (pick == 6) kind = WAVE_IN_STEP;
            else if (pick == 7) kind = WAVE_ONE_SIDED;
            else if (pick == 8) kind = WAVE_NOISE;
            else kind = WAVE_FLAT;
            len = ($urandom_range(0, 9) < 2) ? $urandom_range(1, 22) : $urandom_range(21, 40);
            queue_capture(kind, len);
            phase_beats = phase_beats + len;
         end
         wait_for_drain();
      end

      if (verdicts_due.size() != 0)
         report_mismatch("verdicts left over", verdicts_due.size(), 0);

      $display("Ran %0d sample beats in %0d captures over %0d direction settings.",
               beats_accepted, captures_sent, NUM_PHASES + 1);
      $display("Checked %0d results: %0d forward, %0d reverse, %0d none, %0d pass.",
               results_seen, forward_seen, reverse_seen, none_seen, pass_seen);
      if (error_count == 0) begin
         $display("== PASS ==");
      end else begin
         $display("%0d mismatches", error_count);
         $display("== FAIL ==");
      end
      $finish;
   end

endmodule
